// ===== src/ekf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekf_pkg: shared types, constants and helpers
// Payload structs, register indexes, fixed-point constants and the rounding /
// saturation helpers used by the unicycle EKF predictor.
// ----------------------------------------------------------------------------
package ekf_pkg;

  localparam int unsigned CordicStepsDef = 24;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TIME_STEP     = 3'd0,
    REG_PROCESS_NOISE = 3'd1,
    REG_INITIAL_X     = 3'd2,
    REG_INITIAL_Y     = 3'd3,
    REG_INITIAL_HEAD  = 3'd4
  } reg_idx_e;

  localparam logic [16:0] TimeStepRst     = 17'd6554;
  localparam logic [20:0] ProcessNoiseRst = 21'd105;
  localparam logic signed [31:0] OneQ20   = 32'sd1048576;

  // angle constants, Q.32 radians; CORDIC gain, Q30; one hundredth, Q.32
  localparam logic [47:0] TwoPiQ32        = 48'd26986075410;
  localparam logic signed [49:0] PiQ32    = 50'sd13493037705;
  localparam logic signed [49:0] TwoPiS   = 50'sd26986075410;
  localparam logic signed [49:0] HalfPiQ32 = 50'sd6746518852;
  localparam logic signed [33:0] GainQ30  = 34'sd652032874;
  localparam logic signed [32:0] HundredthQ32 = 33'sd42949673;

  // floor(2^56 / TwoPiQ32): quotient estimate for the Q16.16 angle
  localparam logic [21:0] RecipTwoPi      = 22'd2670176;

  // arctangent of 2^-i, Q2.30
  localparam logic [29:0] AtanQ30 [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  typedef struct packed {
    logic               restart;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_velocity;
    logic signed [19:0] noise_x;
    logic signed [19:0] noise_y;
    logic signed [19:0] noise_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
    logic signed [31:0] cov_xx;
    logic signed [31:0] cov_xy;
    logic signed [31:0] cov_xh;
    logic signed [31:0] cov_yy;
    logic signed [31:0] cov_yh;
    logic signed [31:0] cov_hh;
  } out_item_t;

  // round half up, then arithmetic shift right
  function automatic logic signed [66:0] shr_rnd(input logic signed [66:0] v,
                                                 input int unsigned sh);
    logic signed [66:0] bias;
    bias = 67'sd1 <<< (sh - 1);
    return (v + bias) >>> sh;
  endfunction

  // clamp to signed 32 bit
  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -67'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== src/ekf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekf_mul: shared registered multiplier
// One signed 33 x 33 product per cycle, result registered.
// ----------------------------------------------------------------------------
module ekf_mul
  import ekf_pkg::*;
(
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  // product register, payload only
  always_ff @(posedge clk_i) begin
    p_q <= 66'(a_i) * 66'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== src/ekf_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekf_cordic: iterative sine / cosine
// Reduces a Q16.16 angle modulo 2*pi by reciprocal multiplication and one
// correcting subtract, folds it into [-pi/2, pi/2] and runs one CORDIC
// rotation per cycle. Outputs are Q2.30.
// ----------------------------------------------------------------------------
module ekf_cordic
  import ekf_pkg::*;
#(
  parameter int unsigned Steps = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int unsigned IdxW = $clog2(Steps);

  typedef enum logic [2:0] {C_IDLE, C_RED, C_MOD, C_FOLD, C_ROT, C_OUT} cstate_e;

  cstate_e            state_q;
  logic [31:0]        ang_q;
  logic [13:0]        quo_q;
  logic [47:0]        rem_q;
  logic               sgn_q;
  logic               neg_q;
  logic [IdxW-1:0]    i_q;
  logic signed [33:0] x_q, y_q, z_q;

  logic [31:0]        ang_abs;
  logic [53:0]        qprod;
  logic [47:0]        rem_c;
  logic signed [49:0] r0, r1, r2;
  logic               fneg;
  logic signed [33:0] dx, dy, atn;

  assign ang_abs = angle_i[31] ? 32'(-angle_i) : angle_i;

  // quotient estimate is exact or one low; one subtract corrects it
  assign qprod = 54'(ang_q) * 54'(RecipTwoPi);
  assign rem_c = (rem_q >= TwoPiQ32) ? rem_q - TwoPiQ32 : rem_q;

  // fold the reduced angle into [-pi/2, pi/2]
  always_comb begin
    r0 = sgn_q ? -$signed({2'b00, rem_c}) : $signed({2'b00, rem_c});
    r1 = r0;
    if (r1 > PiQ32) r1 = r1 - TwoPiS;
    if (r1 < -PiQ32) r1 = r1 + TwoPiS;
    r2   = r1;
    fneg = 1'b0;
    if (r1 > HalfPiQ32) begin
      r2   = r1 - PiQ32;
      fneg = 1'b1;
    end else if (r1 < -HalfPiQ32) begin
      r2   = r1 + PiQ32;
      fneg = 1'b1;
    end
  end

  assign dx  = x_q >>> i_q;
  assign dy  = y_q >>> i_q;
  assign atn = $signed({4'b0000, AtanQ30[5'(i_q)]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      ang_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      sgn_q   <= 1'b0;
      neg_q   <= 1'b0;
      i_q     <= '0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            ang_q   <= ang_abs;
            sgn_q   <= angle_i[31];
            state_q <= C_RED;
          end
        end
        // turns of 2*pi in the magnitude
        C_RED: begin
          quo_q   <= qprod[53:40];
          state_q <= C_MOD;
        end
        C_MOD: begin
          rem_q   <= {ang_q, 16'b0} - (48'(quo_q) * TwoPiQ32);
          state_q <= C_FOLD;
        end
        C_FOLD: begin
          z_q     <= 34'((r2 + 50'sd2) >>> 2);
          neg_q   <= fneg;
          x_q     <= GainQ30;
          y_q     <= '0;
          i_q     <= '0;
          state_q <= C_ROT;
        end
        // one micro-rotation per cycle
        C_ROT: begin
          if (!z_q[33]) begin
            x_q <= x_q - dy;
            y_q <= y_q + dx;
            z_q <= z_q - atn;
          end else begin
            x_q <= x_q + dy;
            y_q <= y_q - dx;
            z_q <= z_q + atn;
          end
          if (i_q == IdxW'(Steps - 1)) state_q <= C_OUT;
          else i_q <= i_q + 1'b1;
        end
        C_OUT: state_q <= C_IDLE;
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == C_OUT);
  assign cos_o  = neg_q ? 32'(-x_q) : 32'(x_q);
  assign sin_o  = neg_q ? 32'(-y_q) : 32'(y_q);

endmodule

// ===== src/ekf_unicycle_predict_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekf_unicycle_predict_top: EKF prediction for a planar unicycle pose
// Sequencer around one shared multiplier and one iterative CORDIC unit.
// ----------------------------------------------------------------------------
// One item at a time. A restart item skips all arithmetic and goes straight
// to the done state once it is taken. A prediction item runs 18 products
// through the shared multiplier and two sine/cosine evaluations, each an
// angle reduction and fold followed by one CORDIC rotation per cycle.
// in_ready_o is low while an item is in work; a finished result waits in
// the output register.
// Configuration writes take effect immediately; new initial pose values are
// used at the next restart item.
module ekf_unicycle_predict_top
  import ekf_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WB, S_CORD, S_DONE} state_e;

  typedef enum logic [4:0] {
    OP_DIST, OP_TURN, OP_NX, OP_NY, OP_NH, OP_CS_OLD, OP_PX, OP_PY,
    OP_CS_NEW, OP_A, OP_B, OP_M_AXH, OP_M_AHH, OP_M_AAHH, OP_M_AYH,
    OP_M_BXH, OP_M_BHH, OP_M_ABHH, OP_M_BYH, OP_M_BBHH, OP_SUM
  } op_e;

  state_e state_q;
  op_e    op_q;

  // configuration
  logic [16:0]        time_step_q;
  logic [20:0]        process_noise_q;
  logic signed [31:0] init_x_q, init_y_q, init_h_q;

  // filter state
  logic signed [31:0] est_x_q, est_y_q, est_h_q, held_lin_q, held_ang_q;
  logic signed [31:0] p_xx_q, p_xy_q, p_xh_q, p_yy_q, p_yh_q, p_hh_q;

  // item and temporaries
  in_item_t           item_q;
  logic signed [31:0] dist_q, turn_q, nx_q, ny_q, nh_q, c_q, s_q, a_q, b_q;
  logic signed [31:0] m_axh_q, m_ahh_q, m_aahh_q, m_ayh_q, m_bxh_q;
  logic signed [31:0] m_bhh_q, m_abhh_q, m_byh_q, m_bbhh_q;

  logic               out_valid_q;
  out_item_t          out_data_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [66:0] pw;
  logic               cord_start, cord_done;
  logic signed [31:0] cord_cos, cord_sin;
  logic signed [66:0] q_ext;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign pw          = 67'(prod);
  assign q_ext       = $signed({46'b0, process_noise_q});
  assign cord_start  = (state_q == S_ISSUE) && (op_q == OP_CS_OLD || op_q == OP_CS_NEW);

  // multiplier operand select
  always_comb begin
    mul_a = 33'(dist_q);
    mul_b = 33'(c_q);
    case (op_q)
      OP_DIST:   begin mul_a = 33'(held_lin_q); mul_b = $signed({16'b0, time_step_q}); end
      OP_TURN:   begin mul_a = 33'(held_ang_q); mul_b = $signed({16'b0, time_step_q}); end
      OP_NX:     begin mul_a = 33'(item_q.noise_x); mul_b = HundredthQ32; end
      OP_NY:     begin mul_a = 33'(item_q.noise_y); mul_b = HundredthQ32; end
      OP_NH:     begin mul_a = 33'(item_q.noise_heading); mul_b = HundredthQ32; end
      OP_PX:     begin mul_a = 33'(dist_q); mul_b = 33'(c_q); end
      OP_PY:     begin mul_a = 33'(dist_q); mul_b = 33'(s_q); end
      OP_A:      begin mul_a = -(33'(dist_q)); mul_b = 33'(s_q); end
      OP_B:      begin mul_a = 33'(dist_q); mul_b = 33'(c_q); end
      OP_M_AXH:  begin mul_a = 33'(a_q); mul_b = 33'(p_xh_q); end
      OP_M_AHH:  begin mul_a = 33'(a_q); mul_b = 33'(p_hh_q); end
      OP_M_AAHH: begin mul_a = 33'(a_q); mul_b = 33'(m_ahh_q); end
      OP_M_AYH:  begin mul_a = 33'(a_q); mul_b = 33'(p_yh_q); end
      OP_M_BXH:  begin mul_a = 33'(b_q); mul_b = 33'(p_xh_q); end
      OP_M_BHH:  begin mul_a = 33'(b_q); mul_b = 33'(p_hh_q); end
      OP_M_ABHH: begin mul_a = 33'(a_q); mul_b = 33'(m_bhh_q); end
      OP_M_BYH:  begin mul_a = 33'(b_q); mul_b = 33'(p_yh_q); end
      OP_M_BBHH: begin mul_a = 33'(b_q); mul_b = 33'(m_bhh_q); end
      default:   begin mul_a = 33'(dist_q); mul_b = 33'(c_q); end
    endcase
  end

  ekf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  ekf_cordic #(
    .Steps (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (est_h_q),
    .done_o  (cord_done),
    .cos_o   (cord_cos),
    .sin_o   (cord_sin)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q     <= TimeStepRst;
      process_noise_q <= ProcessNoiseRst;
      init_x_q        <= '0;
      init_y_q        <= '0;
      init_h_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TIME_STEP:     time_step_q     <= cfg_data_i[16:0];
        REG_PROCESS_NOISE: process_noise_q <= cfg_data_i[20:0];
        REG_INITIAL_X:     init_x_q        <= cfg_data_i;
        REG_INITIAL_Y:     init_y_q        <= cfg_data_i;
        REG_INITIAL_HEAD:  init_h_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // payload temporaries, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_data_i;
    if (state_q == S_CORD && cord_done) begin
      c_q <= cord_cos;
      s_q <= cord_sin;
    end
    if (state_q == S_WB) begin
      case (op_q)
        OP_DIST:   dist_q   <= sat32(shr_rnd(pw, 16));
        OP_TURN:   turn_q   <= sat32(shr_rnd(pw, 16));
        OP_NX:     nx_q     <= sat32(shr_rnd(pw, 32));
        OP_NY:     ny_q     <= sat32(shr_rnd(pw, 32));
        OP_NH:     nh_q     <= sat32(shr_rnd(pw, 32));
        OP_A:      a_q      <= sat32(shr_rnd(pw, 30));
        OP_B:      b_q      <= sat32(shr_rnd(pw, 30));
        OP_M_AXH:  m_axh_q  <= sat32(shr_rnd(pw, 16));
        OP_M_AHH:  m_ahh_q  <= sat32(shr_rnd(pw, 16));
        OP_M_AAHH: m_aahh_q <= sat32(shr_rnd(pw, 16));
        OP_M_AYH:  m_ayh_q  <= sat32(shr_rnd(pw, 16));
        OP_M_BXH:  m_bxh_q  <= sat32(shr_rnd(pw, 16));
        OP_M_BHH:  m_bhh_q  <= sat32(shr_rnd(pw, 16));
        OP_M_ABHH: m_abhh_q <= sat32(shr_rnd(pw, 16));
        OP_M_BYH:  m_byh_q  <= sat32(shr_rnd(pw, 16));
        OP_M_BBHH: m_bbhh_q <= sat32(shr_rnd(pw, 16));
        default: ;
      endcase
    end
  end

  // sequencer, filter state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_DIST;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      est_x_q     <= '0;
      est_y_q     <= '0;
      est_h_q     <= '0;
      held_lin_q  <= '0;
      held_ang_q  <= '0;
      p_xx_q      <= OneQ20;
      p_xy_q      <= '0;
      p_xh_q      <= '0;
      p_yy_q      <= OneQ20;
      p_yh_q      <= '0;
      p_hh_q      <= OneQ20;
    end else begin
      // output valid: load a finished item, else drop once taken
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_data_i.restart) begin
              est_x_q    <= init_x_q;
              est_y_q    <= init_y_q;
              est_h_q    <= init_h_q;
              held_lin_q <= '0;
              held_ang_q <= '0;
              p_xx_q     <= OneQ20;
              p_xy_q     <= '0;
              p_xh_q     <= '0;
              p_yy_q     <= OneQ20;
              p_yh_q     <= '0;
              p_hh_q     <= OneQ20;
              state_q    <= S_DONE;
            end else begin
              op_q    <= OP_DIST;
              state_q <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (op_q == OP_CS_OLD || op_q == OP_CS_NEW) begin
            state_q <= S_CORD;
          end else if (op_q == OP_SUM) begin
            // covariance update and velocity hand-over
            p_xx_q <= sat32(67'(p_xx_q) + (67'(m_axh_q) <<< 1) + 67'(m_aahh_q) + q_ext);
            p_xy_q <= sat32(67'(p_xy_q) + 67'(m_ayh_q) + 67'(m_bxh_q) + 67'(m_abhh_q));
            p_xh_q <= sat32(67'(p_xh_q) + 67'(m_ahh_q));
            p_yy_q <= sat32(67'(p_yy_q) + (67'(m_byh_q) <<< 1) + 67'(m_bbhh_q) + q_ext);
            p_yh_q <= sat32(67'(p_yh_q) + 67'(m_bhh_q));
            p_hh_q <= sat32(67'(p_hh_q) + q_ext);
            held_lin_q <= item_q.linear_velocity;
            held_ang_q <= item_q.angular_velocity;
            state_q    <= S_DONE;
          end else begin
            state_q <= S_WB;
          end
        end
        S_WB: begin
          // pose moves once the products are in
          if (op_q == OP_PX) begin
            est_x_q <= sat32(67'(est_x_q) + shr_rnd(pw, 30) + 67'(nx_q));
          end
          if (op_q == OP_PY) begin
            est_y_q <= sat32(67'(est_y_q) + shr_rnd(pw, 30) + 67'(ny_q));
            est_h_q <= sat32(67'(est_h_q) + 67'(turn_q) + 67'(nh_q));
          end
          op_q    <= op_e'(op_q + 5'd1);
          state_q <= S_ISSUE;
        end
        S_CORD: begin
          if (cord_done) begin
            op_q    <= op_e'(op_q + 5'd1);
            state_q <= S_ISSUE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_data_q  <= '{pose_x: est_x_q, pose_y: est_y_q, pose_heading: est_h_q,
                             cov_xx: p_xx_q, cov_xy: p_xy_q, cov_xh: p_xh_q,
                             cov_yy: p_yy_q, cov_yh: p_yh_q, cov_hh: p_hh_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a restart item leaves identity variance on heading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.restart) |=> (p_hh_q == OneQ20))
    else $error("restart did not reset heading variance");

  // heading variance starts at one, never shrinks but at a restart, and never goes negative
  assert property (@(posedge clk_i) disable iff (!rst_ni) !p_hh_q[31])
    else $error("heading variance went negative");

  // CORDIC only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> (state_q == S_CORD))
    else $error("unexpected CORDIC completion");

  // no new item while one is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while busy");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for ekf_unicycle_predict_top
// Drives odometry and restart items over valid/ready with random gaps and
// output stalls. A scoreboard class predicts pose and covariance for each
// accepted item and checks every result, field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ekf_pkg::*;

  localparam int unsigned  Steps      = CordicStepsDef;
  localparam longint       PiQ32L     = 64'sd13493037705;
  localparam longint       HalfPiQ32L = 64'sd6746518852;
  localparam longint       GainQ30L   = 64'sd652032874;
  localparam longint       CentQ32    = 64'sd42949673;
  localparam longint       OneQ20L    = 64'sd1048576;
  localparam logic [2:0]   RegUnused  = 3'd7;
  localparam int unsigned  CycleLimit = 3000000;
  localparam int unsigned  PhaseItems = 92;

  // --------------------------------------------------------------------------
  // pose / covariance predictor and result store
  // --------------------------------------------------------------------------
  class ekf_scoreboard;
    longint    step_dt, q_noise, init_x, init_y, init_h;
    longint    px, py, ph, vel_lin, vel_ang;
    longint    cxx, cxy, cxh, cyy, cyh, chh;
    out_item_t pose_queue[$];
    int        errors;
    int        restarts, moves, checked;

    function new();
      step_dt = 6554; q_noise = 105;
      init_x = 0; init_y = 0; init_h = 0;
      errors = 0; restarts = 0; moves = 0; checked = 0;
      load_start();
    endfunction

    function void load_start();
      px = init_x; py = init_y; ph = init_h;
      vel_lin = 0; vel_ang = 0;
      cxx = OneQ20L; cyy = OneQ20L; chh = OneQ20L;
      cxy = 0; cxh = 0; cyh = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_TIME_STEP:     step_dt = longint'(data[16:0]);
        REG_PROCESS_NOISE: q_noise = longint'(data[20:0]);
        REG_INITIAL_X:     init_x  = longint'(signed'(data));
        REG_INITIAL_Y:     init_y  = longint'(signed'(data));
        REG_INITIAL_HEAD:  init_h  = longint'(signed'(data));
        default: ;
      endcase
    endfunction

    function longint rnd_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint fmul(longint f, longint p);
      return clamp32(rnd_shift(f * p, 16));
    endfunction

    // CORDIC sine/cosine, Q2.30, of a Q16.16 angle
    function void sin_cos(longint ang, output longint c, output longint s);
      longint r, x, y, z, t, dx, dy;
      bit     flip;
      r = ang * 65536;
      r = r - (r / (2 * PiQ32L)) * (2 * PiQ32L);
      if (r > PiQ32L) r = r - 2 * PiQ32L;
      if (r < -PiQ32L) r = r + 2 * PiQ32L;
      flip = 0;
      if (r > HalfPiQ32L) begin
        r = r - PiQ32L; flip = 1;
      end else if (r < -HalfPiQ32L) begin
        r = r + PiQ32L; flip = 1;
      end
      z = rnd_shift(r, 2);
      x = GainQ30L; y = 0;
      for (int i = 0; i < Steps && i < 32; i++) begin
        dx = x >>> i; dy = y >>> i;
        if (z >= 0) begin
          t = x - dy; y = y + dx; x = t; z = z - longint'(AtanQ30[i]);
        end else begin
          t = x + dy; y = y - dx; x = t; z = z + longint'(AtanQ30[i]);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void note_input(in_item_t it);
      longint    step_len, turn, nx, ny, nh, c, s, a, b, xx, xy, xh, yy, yh;
      out_item_t exp_item;
      if (it.restart) begin
        load_start();
        restarts++;
      end else begin
        step_len = clamp32(rnd_shift(vel_lin * step_dt, 16));
        turn = clamp32(rnd_shift(vel_ang * step_dt, 16));
        nx = rnd_shift(longint'(it.noise_x) * CentQ32, 32);
        ny = rnd_shift(longint'(it.noise_y) * CentQ32, 32);
        nh = rnd_shift(longint'(it.noise_heading) * CentQ32, 32);
        sin_cos(ph, c, s);
        px = clamp32(px + rnd_shift(step_len * c, 30) + nx);
        py = clamp32(py + rnd_shift(step_len * s, 30) + ny);
        ph = clamp32(ph + turn + nh);
        // Jacobian terms from the new heading
        sin_cos(ph, c, s);
        a = clamp32(rnd_shift(-step_len * s, 30));
        b = clamp32(rnd_shift(step_len * c, 30));
        xx = cxx + 2 * fmul(a, cxh) + fmul(a, fmul(a, chh)) + q_noise;
        xy = cxy + fmul(a, cyh) + fmul(b, cxh) + fmul(a, fmul(b, chh));
        xh = cxh + fmul(a, chh);
        yy = cyy + 2 * fmul(b, cyh) + fmul(b, fmul(b, chh)) + q_noise;
        yh = cyh + fmul(b, chh);
        chh = clamp32(chh + q_noise);
        cxx = clamp32(xx); cxy = clamp32(xy); cxh = clamp32(xh);
        cyy = clamp32(yy); cyh = clamp32(yh);
        vel_lin = longint'(it.linear_velocity);
        vel_ang = longint'(it.angular_velocity);
        moves++;
      end
      exp_item.pose_x = px[31:0]; exp_item.pose_y = py[31:0];
      exp_item.pose_heading = ph[31:0];
      exp_item.cov_xx = cxx[31:0]; exp_item.cov_xy = cxy[31:0];
      exp_item.cov_xh = cxh[31:0]; exp_item.cov_yy = cyy[31:0];
      exp_item.cov_yh = cyh[31:0]; exp_item.cov_hh = chh[31:0];
      pose_queue = {pose_queue, exp_item};
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pose_queue.size() == 0) begin
        $error("result with no item pending");
        errors++;
        return;
      end
      e = pose_queue.pop_front();
      checked++;
      cmp("pose_x", e.pose_x, got.pose_x);
      cmp("pose_y", e.pose_y, got.pose_y);
      cmp("pose_heading", e.pose_heading, got.pose_heading);
      cmp("cov_xx", e.cov_xx, got.cov_xx);
      cmp("cov_xy", e.cov_xy, got.cov_xy);
      cmp("cov_xh", e.cov_xh, got.cov_xh);
      cmp("cov_yy", e.cov_yy, got.cov_yy);
      cmp("cov_yh", e.cov_yh, got.cov_yh);
      cmp("cov_hh", e.cov_hh, got.cov_hh);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = REG_TIME_STEP;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;

  ekf_scoreboard sb = new();
  int unsigned   cycles = 0;
  bit            no_idle = 0;

  ekf_unicycle_predict_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // mostly short, a few long
  function automatic int unsigned idle_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 4);
  endfunction

  // result side: random stalls, checks at the rising edge
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      stall = idle_len();
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_data_o);
    end
  end

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pose_queue.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  function automatic in_item_t make_item(bit small_vel);
    in_item_t it;
    it.restart = ($urandom_range(0, 11) == 0);
    it.linear_velocity  = small_vel ? $signed($urandom_range(0, 1 << 19)) - (1 << 18)
                                    : $urandom;
    it.angular_velocity = small_vel ? $signed($urandom_range(0, 1 << 19)) - (1 << 18)
                                    : $urandom;
    it.noise_x       = 20'($urandom);
    it.noise_y       = 20'($urandom);
    it.noise_heading = 20'($urandom);
    return it;
  endfunction

  function automatic in_item_t odo(logic [31:0] lv, logic [31:0] av, logic [19:0] n);
    in_item_t it;
    it.restart = 1'b0;
    it.linear_velocity = lv; it.angular_velocity = av;
    it.noise_x = n; it.noise_y = ~n; it.noise_heading = n;
    return it;
  endfunction

  initial begin
    logic [31:0] cfg_set [8][5] = '{
      '{32'd6554, 32'd105, 32'd0, 32'd0, 32'd0},
      '{32'd1, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd205887},
      '{32'd65536, 32'd1048576, -32'sd65536000, 32'sd131072000, -32'sd205887},
      '{32'd0, 32'h1F_FFFF, 32'd12345, -32'sd54321, 32'd102944},
      '{32'h1_FFFF, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{32'd32768, 32'd1, 32'd0, 32'd0, 32'h8000_0000},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd411774},
      '{32'd6554, 32'd105, 32'd0, 32'd0, 32'd0}
    };
    in_item_t it;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset state, field extremes, restart with junk fields
    it = odo(32'sd65536, 32'sd6554, 20'd0);      send_item(it);
    it = odo(32'h7FFF_FFFF, 32'h8000_0000, 20'h7FFFF); send_item(it);
    it = odo(32'h8000_0000, 32'h7FFF_FFFF, 20'h80000); send_item(it);
    it = odo(32'hFFFF_FFFF, 32'd1, 20'hFFFFF);     send_item(it);
    it = odo(32'd0, 32'd0, 20'd1);                 send_item(it);
    it = odo(32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'h7FFFF); send_item(it);
    it = odo(32'd0, 32'd0, 20'h80000);             send_item(it);
    it = odo(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF); it.restart = 1'b1; send_item(it);
    it = odo(32'sd131072, -32'sd65536, 20'd0);     send_item(it);
    it = odo(32'sd131072, -32'sd65536, 20'd0);     send_item(it);
    drain();
    write_reg(RegUnused, 32'hDEAD_BEEF);
    for (int k = 0; k < 4; k++) begin
      it = odo($urandom, $urandom, 20'($urandom)); send_item(it);
    end

    // random phases, one register setting each
    for (int p = 0; p < 8; p++) begin
      drain();
      for (int r = 0; r < 5; r++) write_reg(r[2:0], cfg_set[p][r]);
      if (p == 6) write_reg(REG_TIME_STEP, $urandom_range(1, 65536));
      it = odo('0, '0, '0); it.restart = 1'b1; send_item(it);
      no_idle = (p == 3);
      for (int k = 0; k < PhaseItems; k++) begin
        it = make_item((p + k / 20) % 2 == 0);
        send_item(it);
      end
      no_idle = 1'b0;
    end

    drain();
    repeat (150) @(negedge clk_i);
    $display("Covered %0d prediction items and %0d restarts over 9 register settings,",
             sb.moves, sb.restarts);
    $display("%0d results checked with random gaps and output stalls.", sb.checked);
    if (sb.errors == 0 && sb.pose_queue.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ekf_pkg.sv
src/ekf_mul.sv
src/ekf_cordic.sv
src/ekf_unicycle_predict_top.sv
test/tb_top.sv
